FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("%m: forbidden condition seen");

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication failed");

`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define ASSERT_NEVER(label, clk, rstn, expr)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/cesd_pkg.sv
// shared types, constants and helpers of the escape sequence decoder
// no dependencies
package cesd_pkg;

    localparam int VALUE_W  = 32;   // accumulator width, hex shifting wraps here
    localparam int OUT_W    = 32;   // width of the value field of a result
    localparam int CHAR_W   = 8;
    localparam int CFG_W    = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_W-1:0] CHAR_MASK_RESET = 32'd255;

    // characters
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_QMARK  = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_B   = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LC_F   = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LC_N   = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_LC_R   = 8'h72;
    localparam logic [CHAR_W-1:0] CH_LC_T   = 8'h74;
    localparam logic [CHAR_W-1:0] CH_LC_V   = 8'h76;
    localparam logic [CHAR_W-1:0] CH_LC_X   = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_F   = 8'h46;
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_7      = 8'h37;
    localparam logic [CHAR_W-1:0] CH_8      = 8'h38;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7E;

    // control codes
    localparam logic [CHAR_W-1:0] CC_BEL = 8'd7;
    localparam logic [CHAR_W-1:0] CC_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CC_FF  = 8'd12;
    localparam logic [CHAR_W-1:0] CC_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CC_CR  = 8'd13;
    localparam logic [CHAR_W-1:0] CC_HT  = 8'd9;
    localparam logic [CHAR_W-1:0] CC_VT  = 8'd11;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             from_escape;
        logic             bad_escape;
        logic             bad_is_printable;
        logic             too_large;
        logic             octal_then_8_or_9;
        logic             octal_then_digit;
        logic             last;
    } result_t;

    // one accepted input word: one or two results
    typedef struct packed {
        result_t first;
        result_t second;
        logic    has_second;
    } entry_t;

    function automatic result_t make_result(
        input logic [VALUE_W-1:0] v,
        input logic [VALUE_W-1:0] lim,
        input logic fe,
        input logic bad,
        input logic pr,
        input logic tl,
        input logic o89,
        input logic od
    );
        result_t r;
        r.value             = OUT_W'(v & lim);
        r.from_escape       = fe;
        r.bad_escape        = bad;
        r.bad_is_printable  = pr;
        r.too_large         = tl;
        r.octal_then_8_or_9 = o89;
        r.octal_then_digit  = od;
        r.last              = 1'b0;
        return r;
    endfunction

endpackage

FILE: rtl/cesd_front.sv
// front end: accepts characters, runs the escape state machine, builds queue entries
// depends on cesd_pkg
module cesd_front import cesd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CHAR_W-1:0]  ch,
    input  logic               flush,
    input  logic [VALUE_W-1:0] lim,
    input  logic               q_full,
    output logic               q_push,
    output entry_t             q_entry
);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_BS   = 5'b00010,
        M_HEXF = 5'b00100,
        M_HEXD = 5'b01000,
        M_OCT  = 5'b10000
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;

    logic               accept;
    logic               hex_ok;
    logic [3:0]         hex_d;
    logic               oct_ok;
    logic               is_digit;
    logic               is_print;
    logic [VALUE_W-1:0] allowed;
    logic               close_v;
    result_t            close_r;
    logic               fresh_en;
    logic               fresh_v;
    result_t            fresh_r;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    assign hex_ok   = ch inside {[CH_0:CH_9], [CH_LC_A:CH_LC_F], [CH_UC_A:CH_UC_F]};
    // letters have the low nibble 1..6 for a..f / A..F
    assign hex_d    = ch[6] ? (ch[3:0] + 4'd9) : ch[3:0];
    assign oct_ok   = ch inside {[CH_0:CH_7]};
    assign is_digit = ch inside {[CH_0:CH_9]};
    assign is_print = ch inside {[CH_PRINT_LO:CH_PRINT_HI]};
    assign allowed  = lim >> 4;

    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        close_v   = 1'b0;
        close_r   = make_result('0, lim, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        fresh_en  = 1'b0;
        fresh_v   = 1'b0;
        fresh_r   = make_result(VALUE_W'(ch), lim, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);

        case (mode_reg)
            M_BS: begin
                mode_next = M_IDLE;
                if (flush) begin
                    close_v = 1'b1;
                    close_r = make_result('0, lim, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
                end else begin
                    close_v = 1'b1;
                    case (ch)
                        CH_LC_A: close_r = make_result(VALUE_W'(CC_BEL), lim,
                                                       1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                        CH_LC_B: close_r = make_result(VALUE_W'(CC_BS), lim,
                                                       1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                        CH_LC_F: close_r = make_result(VALUE_W'(CC_FF), lim,
                                                       1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                        CH_LC_N: close_r = make_result(VALUE_W'(CC_LF), lim,
                                                       1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                        CH_LC_R: close_r = make_result(VALUE_W'(CC_CR), lim,
                                                       1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                        CH_LC_T: close_r = make_result(VALUE_W'(CC_HT), lim,
                                                       1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                        CH_LC_V: close_r = make_result(VALUE_W'(CC_VT), lim,
                                                       1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                        CH_SQUOTE, CH_DQUOTE, CH_BSLASH, CH_QMARK: begin
                            close_r = make_result(VALUE_W'(ch), lim,
                                                  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                        end
                        CH_LC_X: begin
                            close_v   = 1'b0;
                            mode_next = M_HEXF;
                            acc_next  = '0;
                            ovf_next  = 1'b0;
                            cnt_next  = 2'd0;
                        end
                        default: begin
                            if (oct_ok) begin
                                close_v   = 1'b0;
                                mode_next = M_OCT;
                                acc_next  = VALUE_W'(ch[2:0]);
                                cnt_next  = 2'd1;
                                ovf_next  = 1'b0;
                            end else begin
                                // unknown escape character
                                close_r = make_result(VALUE_W'(ch), lim,
                                                      1'b1, 1'b1, is_print, 1'b0, 1'b0, 1'b0);
                            end
                        end
                    endcase
                end
            end
            M_HEXF, M_HEXD: begin
                if (!flush && hex_ok) begin
                    if ((acc_reg & ~allowed) != '0) begin
                        ovf_next = 1'b1;
                    end
                    acc_next  = (acc_reg << 4) | VALUE_W'(hex_d);
                    mode_next = M_HEXD;
                end else begin
                    mode_next = M_IDLE;
                    close_v   = 1'b1;
                    fresh_en  = !flush;
                    if (mode_reg == M_HEXF) begin
                        // \x with no hex digit
                        close_r = make_result('0, lim, 1'b1, 1'b1, !flush && is_print,
                                              1'b0, 1'b0, 1'b0);
                    end else begin
                        close_r = make_result(acc_reg, lim, 1'b1, 1'b0, 1'b0,
                                              ovf_reg, 1'b0, 1'b0);
                    end
                end
            end
            M_OCT: begin
                if (!flush && cnt_reg < 2'd3 && oct_ok) begin
                    acc_next = (acc_reg << 3) | VALUE_W'(ch[2:0]);
                    cnt_next = cnt_reg + 2'd1;
                end else begin
                    mode_next = M_IDLE;
                    close_v   = 1'b1;
                    fresh_en  = !flush;
                    close_r   = make_result(acc_reg, lim, 1'b1, 1'b0, 1'b0,
                                            acc_reg > lim,
                                            !flush && cnt_reg < 2'd3 &&
                                                (ch == CH_8 || ch == CH_9),
                                            !flush && is_digit && cnt_reg == 2'd3);
                end
            end
            default: begin
                mode_next = M_IDLE;
                fresh_en  = !flush;
            end
        endcase

        // character that starts fresh after a closed sequence (or from idle)
        if (fresh_en) begin
            if (ch == CH_BSLASH) begin
                mode_next = M_BS;
            end else begin
                fresh_v = 1'b1;
            end
        end
    end

    always_comb begin
        if (close_v) begin
            q_entry.first      = close_r;
            q_entry.second     = fresh_r;
            q_entry.has_second = fresh_v;
        end else begin
            q_entry.first      = fresh_r;
            q_entry.second     = fresh_r;
            q_entry.has_second = 1'b0;
        end
        q_entry.first.last  = !q_entry.has_second;
        q_entry.second.last = 1'b1;
        q_push = accept && (close_v || fresh_v);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            acc_reg  <= '0;
            cnt_reg  <= 2'd0;
            ovf_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

FILE: rtl/cesd_queue.sv
// short queue of decoded entries between front and back
// depends on cesd_pkg
module cesd_queue import cesd_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    output logic   head_valid,
    output entry_t head,
    input  logic   pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/cesd_back.sv
// back end: splits queue entries into single results and holds the output register
// depends on cesd_pkg
module cesd_back import cesd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    head_valid,
    input  entry_t  head,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    result_t res_reg;
    logic    sel_reg;   // 1 while the second result of the head entry is due
    logic    load;
    logic    take_last;

    assign load      = head_valid && (!valid_reg || out_ready);
    assign take_last = sel_reg || !head.has_second;
    assign pop       = load && take_last;

    assign out_valid  = valid_reg;
    assign out_result = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                sel_reg   <= !take_last;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= sel_reg ? head.second : head.first;
        end
    end

endmodule

FILE: rtl/c_escape_sequence_decoder_unit.sv
// top level of the c escape sequence decoder: config register, front, queue, back
// depends on cesd_pkg, cesd_front, cesd_queue, cesd_back, assert_macros.svh
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tdata[7:0] ch, tuser flush
//  m_      | out | m_tvalid/m_tready  | tdata[31:0] value, tuser[5:0] flags, tlast
//  cfg_    | in  | cfg_we             | cfg_wdata[31:0] char_mask
//
// one input word per cycle is taken while the four-entry queue has room; the
// front decides next state and results in the cycle it takes the word.
// the back sends one result word per cycle while m_tready is high, so a word that
// closes a sequence and is itself a plain character gives two result words.
// an input word's first result passes through the queue, then the output register.
// aresetn is synchronous; it empties the queue and sets char_mask to 255.
`include "assert_macros.svh"

module c_escape_sequence_decoder_unit import cesd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] ch
    input  logic              s_tuser,   // [0] flush
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [31:0] value
    output logic [5:0]        m_tuser,   // [0] from_escape, [1] bad_escape,
                                         // [2] bad_is_printable, [3] too_large,
                                         // [4] octal_then_8_or_9, [5] octal_then_digit
    output logic              m_tlast,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    logic [CFG_W-1:0] char_mask_reg;
    logic [VALUE_W-1:0] lim;
    logic    q_full, q_push, q_valid, q_pop;
    entry_t  q_entry, q_head;
    result_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_mask_reg <= CHAR_MASK_RESET;
        end else if (cfg_we) begin
            char_mask_reg <= cfg_wdata;
        end
    end

    assign lim = VALUE_W'(char_mask_reg);

    cesd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .ch       (s_tdata),
        .flush    (s_tuser),
        .lim      (lim),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    cesd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop)
    );

    cesd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    assign m_tdata = res.value;
    assign m_tuser = {res.octal_then_digit, res.octal_then_8_or_9, res.too_large,
                      res.bad_is_printable, res.bad_escape, res.from_escape};
    assign m_tlast = res.last;

    // a word with two results always starts with a closed escape
    `ASSERT_IMPLIES(a_first_of_pair_is_escape, aclk, aresetn, m_tvalid && !m_tlast, m_tuser[0])
    // the second result of a pair is already queued when the first is taken
    `ASSERT_NEXT(a_pair_back_to_back, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid)
    `ASSERT_IMPLIES(a_printable_needs_bad, aclk, aresetn, m_tvalid && m_tuser[2], m_tuser[1])
    `ASSERT_NEVER(a_bad_and_too_large, aclk, aresetn, m_tvalid && m_tuser[1] && m_tuser[3])

endmodule
